// File: rtl/msbm_pkg.sv
package msbm_pkg;

  localparam int NUM_SIGS_DEF = 16;
  localparam int MAX_LEN_DEF  = 32;

  // Fixed field widths of the item and result beats
  localparam int OPCODE_W  = 2;
  localparam int SLOT_IN_W = 4;
  localparam int POS_W     = 5;
  localparam int VALUE_W   = 8;
  localparam int START_W   = 32;
  localparam int INDEX_W   = 4;
  localparam int SIG_LEN_W = 6;

  // Only the slots that a 4-bit index can name are scanned
  localparam int SCAN_LIMIT = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_BYTE = 2'd0,
    OP_SET_LEN = 2'd1,
    OP_SCAN    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  // Controller to datapath
  typedef struct packed {
    logic op_exec;  // input beat taken: apply its opcode
    logic rd_en;    // fetch a signature row
    logic advance;  // consume the current slot compare
    logic flush;    // send the held match as the final one
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/msbm_ctrl.sv
module msbm_ctrl
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS = NUM_SIGS_DEF,
  parameter int SLOT_W   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] in_opcode,
  output logic                in_ready,
  input  dp_sts_t             sts,
  output ctl_cmd_t            cmd,
  output logic [SLOT_W-1:0]   rd_slot,
  output logic [SLOT_W-1:0]   cmp_slot
);

  localparam int SCAN_N = (NUM_SIGS < SCAN_LIMIT) ? NUM_SIGS : SCAN_LIMIT;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SCAN_N - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              stall;

  assign cmp_slot = slot_r;
  // A second hit cannot displace the held one while the output beat waits
  assign stall    = sts.hit && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    in_ready    = 1'b0;
    cmd         = '0;
    rd_slot     = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op_exec = 1'b1;
          if (in_opcode == OP_SCAN) begin
            cmd.rd_en = 1'b1;
            rd_slot   = '0;
            slot_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.advance = 1'b1;
          if (slot_r == LAST_SLOT) begin
            state_nxt = ST_FLUSH;
          end else begin
            cmd.rd_en = 1'b1;
            rd_slot   = slot_r + 1'b1;
            slot_nxt  = slot_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_SCAN |=> state_r == ST_SCAN && slot_r == '0)
    else $error("scan did not start at slot zero");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && !cmd.advance |=> state_r == ST_SCAN && $stable(slot_r))
    else $error("slot moved during a stall");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !cmd.op_exec)
    else $error("input beat taken while scanning");

endmodule

// File: rtl/msbm_dp.sv
module msbm_dp
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS = NUM_SIGS_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int SLOT_W   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic [SLOT_IN_W-1:0] in_sig_slot,
  input  logic [POS_W-1:0]     in_byte_pos,
  input  logic [VALUE_W-1:0]   in_value,
  input  ctl_cmd_t             cmd,
  input  logic [SLOT_W-1:0]    rd_slot,
  input  logic [SLOT_W-1:0]    cmp_slot,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [START_W-1:0]   out_match_start,
  output logic [INDEX_W-1:0]   out_sig_index,
  output logic [SIG_LEN_W-1:0] out_sig_len,
  output logic                 out_last
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int HIST_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_W  = MAX_LEN * VALUE_W;

  // Signature table: one row per slot, byte-lane writes
  logic [ROW_W-1:0]   sig_mem [NUM_SIGS];
  logic [ROW_W-1:0]   rd_data_r;
  logic [LEN_W-1:0]   len_r [NUM_SIGS];
  logic [VALUE_W-1:0] hist_r [MAX_LEN];
  logic [START_W-1:0] count_r;

  logic               pend_valid_r;
  logic [START_W-1:0] pend_start_r;
  logic [SLOT_W-1:0]  pend_slot_r;
  logic [LEN_W-1:0]   pend_len_r;

  logic                 out_valid_r;
  logic [START_W-1:0]   out_start_r;
  logic [INDEX_W-1:0]   out_index_r;
  logic [SIG_LEN_W-1:0] out_len_r;
  logic                 out_last_r;

  logic               slot_ok, pos_ok;
  logic [LEN_W-1:0]   sat_len;
  logic [LEN_W-1:0]   cur_len;
  logic               bytes_eq;
  logic               hit;
  logic [START_W-1:0] new_start;
  logic               out_free;
  logic               push_mid, push_last;

  assign slot_ok = 32'(in_sig_slot) < 32'(NUM_SIGS);
  assign pos_ok  = 32'(in_byte_pos) < 32'(MAX_LEN);
  assign sat_len = (32'(in_value) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(in_value);

  // Signature byte k lines up with the byte scanned len-1-k beats ago
  always_comb begin
    logic [HIST_W-1:0] idx;
    cur_len  = len_r[cmp_slot];
    bytes_eq = 1'b1;
    idx      = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (k < int'(cur_len)) begin
        idx = HIST_W'(int'(cur_len) - 1 - k);
        if (hist_r[idx] != rd_data_r[k*VALUE_W +: VALUE_W]) begin
          bytes_eq = 1'b0;
        end
      end
    end
  end

  assign hit       = bytes_eq && (cur_len != '0) && (START_W'(cur_len) <= count_r);
  assign new_start = count_r - START_W'(cur_len);
  assign out_free  = !out_valid_r || out_ready;
  assign push_mid  = cmd.advance && hit && pend_valid_r;
  assign push_last = cmd.flush;

  assign sts.hit        = hit;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.op_exec && in_opcode == OP_WR_BYTE && slot_ok && pos_ok) begin
      sig_mem[SLOT_W'(in_sig_slot)][HIST_W'(in_byte_pos)*VALUE_W +: VALUE_W] <= in_value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= sig_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        len_r[s] <= '0;
      end
      for (int i = 0; i < MAX_LEN; i++) begin
        hist_r[i] <= '0;
      end
      count_r <= '0;
    end else if (cmd.op_exec) begin
      unique case (opcode_t'(in_opcode))
        OP_WR_BYTE: ;
        OP_SET_LEN: begin
          if (slot_ok) begin
            len_r[SLOT_W'(in_sig_slot)] <= sat_len;
          end
        end
        OP_SCAN: begin
          for (int i = MAX_LEN - 1; i > 0; i--) begin
            hist_r[i] <= hist_r[i-1];
          end
          hist_r[0] <= in_value;
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
          end
        end
        OP_RESTART: begin
          for (int i = 0; i < MAX_LEN; i++) begin
            hist_r[i] <= '0;
          end
          count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Hold one match back until the next hit or the end of the sweep sets last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.advance && hit) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance && hit) begin
      pend_start_r <= new_start;
      pend_slot_r  <= cmp_slot;
      pend_len_r   <= cur_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      out_start_r <= pend_start_r;
      out_index_r <= INDEX_W'(pend_slot_r);
      out_len_r   <= SIG_LEN_W'(pend_len_r);
      out_last_r  <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;
  assign out_sig_index   = out_index_r;
  assign out_sig_len     = out_len_r;
  assign out_last        = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push_mid || push_last |-> out_free)
    else $error("result register overwritten while held");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !pend_valid_r)
    else $error("held match survived the final beat");

  a_flush_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> pend_valid_r && !cmd.advance)
    else $error("final beat sent without a held match");

endmodule

// File: rtl/multi_signature_byte_matcher_top.sv
// Load and restart beats are applied when taken and leave the block ready.
// A scan beat fetches the first signature row, compares one slot per step over the
// first min(NUM_SIGS,16) slots of the row table, then sends the held match if any.
// A slot's match goes out when the next matching slot or the end of the sweep is
// reached; a held result beat can stall the sweep. Reset (rst_n, synchronous) clears
// lengths, history and byte count; signature bytes are not cleared.
module multi_signature_byte_matcher_top
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS = NUM_SIGS_DEF,
  parameter int MAX_LEN  = MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic [SLOT_IN_W-1:0] in_sig_slot,
  input  logic [POS_W-1:0]     in_byte_pos,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [START_W-1:0]   out_match_start,
  output logic [INDEX_W-1:0]   out_sig_index,
  output logic [SIG_LEN_W-1:0] out_sig_len,
  output logic                 out_last
);

  localparam int SLOT_W = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;

  ctl_cmd_t          cmd;
  dp_sts_t           sts;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] cmp_slot;

  msbm_ctrl #(
    .NUM_SIGS (NUM_SIGS),
    .SLOT_W   (SLOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_slot   (rd_slot),
    .cmp_slot  (cmp_slot)
  );

  msbm_dp #(
    .NUM_SIGS (NUM_SIGS),
    .MAX_LEN  (MAX_LEN),
    .SLOT_W   (SLOT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_sig_slot     (in_sig_slot),
    .in_byte_pos     (in_byte_pos),
    .in_value        (in_value),
    .cmd             (cmd),
    .rd_slot         (rd_slot),
    .cmp_slot        (cmp_slot),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start),
    .out_sig_index   (out_sig_index),
    .out_sig_len     (out_sig_len),
    .out_last        (out_last)
  );

endmodule
